>>> rtl/core/atnf_pkg.sv
// ----------------------------------------------------------------------------
// atnf_pkg
// Shared types and constants of the announcement record name filter.
// ----------------------------------------------------------------------------
package atnf_pkg;

    // Largest name that can be matched, in bytes.
    localparam int unsigned MAX_NAME_BYTES = 16;
    localparam int unsigned NAME_IDX_W     = $clog2(MAX_NAME_BYTES);

    // Configuration register indexes.
    localparam logic [1:0] CFG_TARGET_TYPE = 2'd0;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd1;
    localparam logic [1:0] CFG_NAME_LOW    = 2'd2;
    localparam logic [1:0] CFG_NAME_HIGH   = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] RST_TARGET_TYPE = 8'h0B;
    localparam logic [4:0] RST_NAME_LENGTH = 5'd16;

    // Parser phase codes.
    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_TYPE   = 2'd1;
    localparam logic [1:0] PH_VALUE  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_MATCH     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef struct packed {
        logic [7:0]  target_type;
        logic [4:0]  name_length;
        logic [63:0] name_high;
        logic [63:0] name_low;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } t_result;

endpackage

>>> rtl/core/atnf_cfg_regs.sv
// ----------------------------------------------------------------------------
// atnf_cfg_regs
// Configuration register file: match type, name length and name bytes.
// ----------------------------------------------------------------------------
module atnf_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    output atnf_pkg::t_cfg o_cfg
);
    import atnf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_type <= RST_TARGET_TYPE;
            r_cfg.name_length <= RST_NAME_LENGTH;
            r_cfg.name_low    <= '0;
            r_cfg.name_high   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_TYPE: r_cfg.target_type <= i_cfg_data[7:0];
                CFG_NAME_LENGTH: r_cfg.name_length <= i_cfg_data[4:0];
                CFG_NAME_LOW:    r_cfg.name_low    <= i_cfg_data;
                CFG_NAME_HIGH:   r_cfg.name_high   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/atnf_parser.sv
// ----------------------------------------------------------------------------
// atnf_parser
// Length-type-value walker: one byte per i_accept cycle, status on last byte.
// ----------------------------------------------------------------------------
module atnf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  atnf_pkg::t_cfg    i_cfg,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output atnf_pkg::t_result o_result
);
    import atnf_pkg::*;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [4:0] r_value_pos, n_value_pos;
    logic       r_cand, n_cand;
    logic       r_decided, n_decided;
    logic [1:0] r_dec_status, n_dec_status;

    logic [7:0]   left_dec;
    logic [7:0]   name_byte;
    logic [127:0] name_all;
    logic         type_cand;
    logic         value_cand;
    logic [1:0]   status;

    assign name_all  = {i_cfg.name_high, i_cfg.name_low};
    assign name_byte = name_all[{r_value_pos[NAME_IDX_W-1:0], 3'b000} +: 8];
    assign left_dec  = r_bytes_left - 8'd1;

    assign type_cand = (i_data_byte == i_cfg.target_type)
                    && (i_cfg.name_length <= 5'(MAX_NAME_BYTES))
                    && ({3'b000, i_cfg.name_length} == left_dec);

    assign value_cand = r_cand && (r_value_pos < 5'(MAX_NAME_BYTES))
                     && (i_data_byte == name_byte);

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_value_pos  = r_value_pos;
        n_cand       = r_cand;
        n_decided    = r_decided;
        n_dec_status = r_dec_status;

        if (!r_decided) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (i_data_byte == 8'd0) begin
                        n_decided    = 1'b1;
                        n_dec_status = ST_MALFORMED;
                    end else begin
                        n_bytes_left = i_data_byte;
                        n_phase      = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_bytes_left = left_dec;
                    n_value_pos  = '0;
                    if (left_dec == 8'd0) begin
                        if (type_cand) begin
                            n_decided    = 1'b1;
                            n_dec_status = ST_MATCH;
                        end
                        n_cand  = 1'b0;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_cand  = type_cand;
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    n_value_pos  = r_value_pos + 5'd1;
                    n_bytes_left = left_dec;
                    if (left_dec == 8'd0) begin
                        if (value_cand) begin
                            n_decided    = 1'b1;
                            n_dec_status = ST_MATCH;
                        end
                        n_cand  = 1'b0;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_cand = value_cand;
                    end
                end
            endcase
        end

        // A record that ends inside a field, with nothing decided, is malformed.
        if (n_decided) begin
            status = n_dec_status;
        end else if (n_phase != PH_LENGTH) begin
            status = ST_MALFORMED;
        end else begin
            status = ST_NONE;
        end

        // The last byte closes the record and the next byte opens a new one.
        if (i_last_byte) begin
            n_phase      = PH_LENGTH;
            n_bytes_left = '0;
            n_value_pos  = '0;
            n_cand       = 1'b0;
            n_decided    = 1'b0;
            n_dec_status = ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LENGTH;
            r_bytes_left <= '0;
            r_value_pos  <= '0;
            r_cand       <= 1'b0;
            r_decided    <= 1'b0;
            r_dec_status <= ST_NONE;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_value_pos  <= n_value_pos;
            r_cand       <= n_cand;
            r_decided    <= n_decided;
            r_dec_status <= n_dec_status;
        end
    end

    assign o_result.valid  = i_accept && i_last_byte;
    assign o_result.status = status;

endmodule

>>> rtl/core/announce_tlv_name_filter.sv
// ----------------------------------------------------------------------------
// announce_tlv_name_filter
// Name filter for announcement records made of length-type-value fields.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall  i_data_byte, i_last_byte
//  out       source     o_out_valid / i_out_stall o_status
//  cfg       sink       i_cfg_we                i_cfg_index, i_cfg_data
//
//  One byte is taken per clock cycle while o_in_stall is low; the walk over
//  the fields updates the parser state once per byte taken. The status of a
//  record is shown on o_status in the cycle after its last byte is taken
//  when the output register is empty or drains as that byte is taken; else
//  it waits in the skid register until the output register drains.
//  Reset is synchronous and clears the parser, the output stages and the
//  configuration registers to their default values.
//  o_in_stall rises only while a second status waits behind a stalled one.
//
module announce_tlv_name_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions: one record byte each.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // Output transactions: one status per record.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import atnf_pkg::*;

    t_cfg    cfg;
    t_result result;
    logic    in_accept;
    logic    out_fire;

    // Output register and the skid register behind it.
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic       r_skid_valid;
    logic [1:0] r_skid_status;

    // The skid register catches a status that arrives while the output
    // register is held, so the input side never waits on the output side
    // combinationally.
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_fire   = r_out_valid && !i_out_stall;

    atnf_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    atnf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // No input is taken while the skid register is full.
            if (out_fire) begin
                r_out_status <= r_skid_status;
                r_skid_valid <= 1'b0;
            end
        end else if (result.valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid  <= 1'b1;
                r_out_status <= result.status;
            end else begin
                r_skid_valid  <= 1'b1;
                r_skid_status <= result.status;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

>>> rtl/core/atnf_checker.sv
// ----------------------------------------------------------------------------
// atnf_checker
// Port-level checks of the name filter, bound to the top level.
// ----------------------------------------------------------------------------
module atnf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status
);
    import atnf_pkg::*;

    logic last_taken;

    assign last_taken = i_in_valid && !o_in_stall && i_last_byte;

    // A held status stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("status changed or dropped while stalled");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_NONE || o_status == ST_MATCH
                         || o_status == ST_MALFORMED))
        else $error("undefined status code");

    // A last byte taken into an empty output stage shows up next cycle.
    a_status_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_taken && !o_out_valid |=> o_out_valid)
        else $error("status of a finished record did not appear");

    // No status appears without a record ending.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !last_taken |=> !o_out_valid)
        else $error("status appeared without a last byte");

endmodule

bind announce_tlv_name_filter atnf_checker u_atnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_last_byte (i_last_byte),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the announcement record name filter. A short table
// of directed records runs first, then six phases of random records under
// different idle and stall patterns. Every status is checked against a typed
// table value, if given, else the bench's own cycle-free field walk model.
// ----------------------------------------------------------------------------
module tb;
    import atnf_pkg::*;

    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 200;
    // Bytes that each random phase sends at least before it is closed.
    localparam int PHASE_BYTES = 64;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_kind;

    // One row of the directed table: either a record byte, with an optional
    // hand-written expected status, or a full set of register values.
    typedef struct {
        t_row_kind  kind;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [1:0] status;
        t_cfg       cfg;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    announce_tlv_name_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Copy of the registers as the bench has written them.
    t_cfg       cfg_m;

    // Copy of the parser state, updated once per accepted byte.
    logic [1:0] walk_phase;
    logic [7:0] walk_left;
    logic [4:0] walk_pos;
    logic       walk_cand;
    logic       walk_decided;
    logic [1:0] walk_status;

    // Statuses that the block still owes, oldest first.
    logic [1:0] pending_status[$];

    // Bytes of the record that is about to be sent.
    logic [7:0] rec_q[$];
    t_dir_row   dir_rows[$];

    int         errors;
    int         send_idle;
    int         stall_pct;
    logic       hold_off;
    event       hold_go;

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Reporting and prediction.
    // ------------------------------------------------------------------------
    task automatic report(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // Name byte at a value position; positions wrap at sixteen like the
    // register layout does.
    function automatic logic [7:0] name_at(input logic [4:0] pos);
        logic [63:0] word;
        word = pos[3] ? cfg_m.name_high : cfg_m.name_low;
        return word[pos[2:0]*8 +: 8];
    endfunction

    function automatic void reset_walk();
        walk_phase   = PH_LENGTH;
        walk_left    = 8'd0;
        walk_pos     = 5'd0;
        walk_cand    = 1'b0;
        walk_decided = 1'b0;
        walk_status  = ST_NONE;
    endfunction

    // A field ends: a surviving candidate decides the record as a match.
    function automatic void close_field();
        if (walk_cand) begin
            walk_decided = 1'b1;
            walk_status  = ST_MATCH;
        end
        walk_cand  = 1'b0;
        walk_phase = PH_LENGTH;
    endfunction

    // Advances the parser copy by one byte. On the last byte of a record it
    // returns the status that the block has to show and starts a new record.
    function automatic logic filter_step(input logic [7:0] d, input logic l,
                                         output logic [1:0] st);
        st = ST_NONE;
        if (!walk_decided) begin
            case (walk_phase)
                PH_LENGTH: begin
                    // A zero length byte can never start a valid field.
                    if (d == 8'd0) begin
                        walk_decided = 1'b1;
                        walk_status  = ST_MALFORMED;
                    end else begin
                        walk_left  = d;
                        walk_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    walk_left = walk_left - 8'd1;
                    walk_pos  = 5'd0;
                    walk_cand = (d == cfg_m.target_type) &&
                                (cfg_m.name_length <= MAX_NAME_BYTES) &&
                                (walk_left == {3'd0, cfg_m.name_length});
                    if (walk_left == 8'd0) begin
                        close_field();
                    end else begin
                        walk_phase = PH_VALUE;
                    end
                end
                default: begin
                    if (walk_cand && (walk_pos >= MAX_NAME_BYTES ||
                                      d != name_at(walk_pos))) begin
                        walk_cand = 1'b0;
                    end
                    walk_pos  = walk_pos + 5'd1;
                    walk_left = walk_left - 8'd1;
                    if (walk_left == 8'd0) begin
                        close_field();
                    end
                end
            endcase
        end
        if (!l) begin
            return 1'b0;
        end
        // A record that ends inside a field is malformed unless something
        // was already decided.
        if (walk_decided) begin
            st = walk_status;
        end else if (walk_phase != PH_LENGTH) begin
            st = ST_MALFORMED;
        end
        reset_walk();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Each one is entered and left right after a rising edge,
    // so every input changes through one nonblocking assignment per step.
    // ------------------------------------------------------------------------

    // Offers one byte, waits until the transaction is taken and then updates
    // the prediction. A typed status, where given, is expected instead of
    // the predicted one.
    task automatic send_byte(input logic [7:0] d, input logic l,
                             input logic typed, input logic [1:0] typed_st);
        logic [1:0] st;
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (filter_step(d, l, st)) begin
            pending_status.push_back(typed ? typed_st : st);
        end
    endtask

    // Writes all four registers on back-to-back edges. Upper bits of
    // the narrow registers carry random junk, which the block has to drop.
    task automatic write_cfg(input t_cfg c);
        logic [63:0] junk;
        for (int idx = 0; idx < 4; idx++) begin
            junk = {$urandom, $urandom};
            i_cfg_we <= 1'b1;
            case (idx)
                0: begin
                    i_cfg_index <= CFG_TARGET_TYPE;
                    i_cfg_data  <= {junk[63:8], c.target_type};
                end
                1: begin
                    i_cfg_index <= CFG_NAME_LENGTH;
                    i_cfg_data  <= {junk[63:5], c.name_length};
                end
                2: begin
                    i_cfg_index <= CFG_NAME_LOW;
                    i_cfg_data  <= c.name_low;
                end
                default: begin
                    i_cfg_index <= CFG_NAME_HIGH;
                    i_cfg_data  <= c.name_high;
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_m = c;
    endtask

    // Stops offering bytes and waits until every owed status has come, then
    // waits on so that the block is surely back at rest.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_dir_row byte_row(input logic [7:0] d, input logic l,
                                          input logic typed,
                                          input logic [1:0] st);
        t_dir_row r;
        r.kind   = ROW_BYTE;
        r.data   = d;
        r.last   = l;
        r.typed  = typed;
        r.status = st;
        r.cfg    = '0;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [7:0] tt,
                                         input logic [4:0] nl,
                                         input logic [63:0] lo,
                                         input logic [63:0] hi);
        t_dir_row r;
        r             = byte_row(8'd0, 1'b0, 1'b0, ST_NONE);
        r.kind        = ROW_CFG;
        r.cfg.target_type = tt;
        r.cfg.name_length = nl;
        r.cfg.name_low    = lo;
        r.cfg.name_high   = hi;
        return r;
    endfunction

    // Random register set. Most names are short to keep records short; a
    // few are empty or longer than the block can ever match.
    function automatic t_cfg random_cfg();
        t_cfg c;
        int   r;
        c.target_type = 8'($urandom);
        r = $urandom_range(99);
        if (r < 60) begin
            c.name_length = 5'($urandom_range(1, 8));
        end else if (r < 80) begin
            c.name_length = 5'($urandom_range(9, 16));
        end else if (r < 90) begin
            c.name_length = 5'd0;
        end else begin
            c.name_length = 5'($urandom_range(17, 31));
        end
        c.name_low  = {$urandom, $urandom};
        c.name_high = {$urandom, $urandom};
        return c;
    endfunction

    // Builds one random record in rec_q. Most records are well-formed field
    // sequences around the configured name; some are cut short or carry a
    // zero length byte, and the rest are plain noise.
    task automatic build_record();
        int         kind;
        int         nf;
        int         pick;
        int         len;
        int         idx;
        int         i;
        logic [7:0] ty;
        rec_q.delete();
        kind = $urandom_range(99);
        if (kind >= 85) begin
            len = $urandom_range(1, 6);
            repeat (len) rec_q.push_back(8'($urandom));
            return;
        end
        nf = $urandom_range(1, 3);
        repeat (nf) begin
            pick = $urandom_range(9);
            if (pick < 4) begin
                // Field that carries the configured name.
                len = cfg_m.name_length + 1;
                ty  = cfg_m.target_type;
            end else if (pick < 6) begin
                // Right type and name, but one byte too short or too long.
                len = cfg_m.name_length + ($urandom_range(1) ? 2 : 0);
                ty  = cfg_m.target_type;
            end else begin
                len = $urandom_range(1, 6);
                ty  = ($urandom_range(3) == 0) ? cfg_m.target_type : 8'($urandom);
            end
            rec_q.push_back(len[7:0]);
            rec_q.push_back(ty);
            for (i = 0; i < len - 1; i++) begin
                rec_q.push_back((pick < 6) ? name_at(i[4:0]) : 8'($urandom));
            end
            // Now and then one name byte is spoiled.
            if (pick < 4 && len > 1 && $urandom_range(3) == 0) begin
                idx = rec_q.size() - 1 - $urandom_range(0, len - 2);
                rec_q[idx] = rec_q[idx] ^ 8'($urandom_range(1, 255));
            end
        end
        if (kind >= 70) begin
            if ($urandom_range(1)) begin
                len = $urandom_range(1, rec_q.size());
                while (rec_q.size() > len) begin
                    void'(rec_q.pop_back());
                end
            end else begin
                rec_q[$urandom_range(rec_q.size() - 1)] = 8'd0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. The stall is random at the rate of the current phase, and it
    // is held high for a long stretch when the hold-off is running.
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    // The hold-off counts its own cycles, so the sender keeps offering bytes
    // meanwhile and the block has to push back on its input.
    initial begin
        hold_off = 1'b0;
        forever begin
            @(hold_go);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
        end
    end

    // Each status transaction is checked against the oldest owed status.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                report($sformatf("status %0d with none owed", o_status));
            end else if (o_status !== pending_status[0]) begin
                report($sformatf("status got %0d, want %0d",
                                 o_status, pending_status[0]));
                void'(pending_status.pop_front());
            end else begin
                void'(pending_status.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int       sent;
        t_cfg     c;
        t_dir_row r;

        errors    = 0;
        send_idle = 0;
        stall_pct = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'd0;
        i_last_byte <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TARGET_TYPE;
        i_cfg_data  <= 64'd0;

        cfg_m.target_type = RST_TARGET_TYPE;
        cfg_m.name_length = RST_NAME_LENGTH;
        cfg_m.name_low    = 64'd0;
        cfg_m.name_high   = 64'd0;
        reset_walk();

        // Directed records. The first group runs on the reset registers.
        // A lone zero length byte is malformed.
        dir_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, ST_MALFORMED));
        // The record ends inside the value of a field.
        dir_rows.push_back(byte_row(8'h05, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h0B, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, ST_MALFORMED));
        // A type-only field cannot match a sixteen byte name.
        dir_rows.push_back(byte_row(8'h01, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h0B, 1'b1, 1'b1, ST_NONE));
        // The record ends right after a length byte.
        dir_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, ST_MALFORMED));

        // One-byte name 0xFF under type 0xFF.
        dir_rows.push_back(cfg_row(8'hFF, 5'd1, 64'hFF, '1));
        dir_rows.push_back(byte_row(8'h02, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, ST_MATCH));
        dir_rows.push_back(byte_row(8'h02, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFE, 1'b1, 1'b1, ST_NONE));
        // After a match the trailing zero length byte is ignored.
        dir_rows.push_back(byte_row(8'h02, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h00, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, ST_MATCH));
        // After a malformed decision a later good field does not count.
        dir_rows.push_back(byte_row(8'h00, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h02, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, ST_MALFORMED));

        // An empty name matches a type-only field of the right type.
        dir_rows.push_back(cfg_row(8'h00, 5'd0, 64'd0, 64'd0));
        dir_rows.push_back(byte_row(8'h01, 1'b0, 1'b0, ST_NONE));
        dir_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, ST_MATCH));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.kind == ROW_CFG) begin
                settle();
                write_cfg(r.cfg);
            end else begin
                send_byte(r.data, r.last, r.typed, r.status);
            end
        end

        // Random phases: no idling, a lazy sender, a lazy receiver, both a
        // little lazy, the long hold-off, and both a little lazy again.
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin send_idle = 0;  stall_pct <= 0;  end
                1: begin send_idle = 75; stall_pct <= 0;  end
                2: begin send_idle = 0;  stall_pct <= 75; end
                4: begin send_idle = 0;  stall_pct <= 0;  end
                default: begin send_idle = 15; stall_pct <= 15; end
            endcase
            c = random_cfg();
            // The longest name and a length past the limit get a phase each.
            if (ph == 0) begin
                c.name_length = 5'd16;
            end else if (ph == 5) begin
                c.name_length = 5'd31;
            end
            write_cfg(c);
            if (ph == 4) begin
                ->hold_go;
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_record();
                foreach (rec_q[k]) begin
                    send_byte(rec_q[k], k == rec_q.size() - 1, 1'b0, ST_NONE);
                end
                sent += rec_q.size();
            end
        end

        settle();
        if (pending_status.size() != 0) begin
            report("statuses still owed at the end");
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
